// ----- rtl/core/afct_pkg.sv -----
package afct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_REG_W = 64;
    localparam int CFG_IDX_W   = 3;

    // plane register index
    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_TOP    = 3'd2,
        PLANE_BOTTOM = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5
    } t_plane_idx;

    // per-stage load enables handed to the plane units
    typedef struct packed {
        logic mul;
        logic sum;
        logic cmp;
    } t_stage_ld;

endpackage

// ----- rtl/core/afct_plane_unit.sv -----
module afct_plane_unit #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 11
) (
    input  logic                                      i_clk,
    input  afct_pkg::t_stage_ld                       i_ld,
    input  logic [afct_pkg::PLANE_REG_W-1:0]          i_plane,
    input  logic signed [COORD_BITS+1:0]              i_op_lo [3],
    input  logic signed [COORD_BITS+1:0]              i_op_hi [3],
    output logic                                      o_pass
);
    import afct_pkg::*;

    localparam int NRM_W   = NORMAL_FRAC_BITS + 1;
    localparam int OFS_POS = 3 * NRM_W;
    localparam int OFS_W   = PLANE_REG_W - OFS_POS;
    localparam int OP_W    = COORD_BITS + 2;
    localparam int PROD_W  = NRM_W + OP_W;
    localparam int OFS_T_W = OFS_W + NRM_W;
    localparam int ACC_W   = ((PROD_W > OFS_T_W) ? PROD_W : OFS_T_W) + 3;

    logic signed [NRM_W-1:0]  w_nrm [3];
    logic signed [OP_W-1:0]   w_op  [3];
    logic signed [PROD_W-1:0] w_prod [3];
    logic signed [OFS_W-1:0]  w_ofs;
    logic signed [ACC_W-1:0]  w_sum;

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_sum;
    logic                     r_pass;

    // n*(2c) + s*|n| folds to n*(2min+2size) for n >= 0, n*(2min) for n < 0
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nrm[i]  = signed'(i_plane[i*NRM_W +: NRM_W]);
            w_op[i]   = w_nrm[i][NRM_W-1] ? i_op_lo[i] : i_op_hi[i];
            w_prod[i] = PROD_W'(w_nrm[i]) * PROD_W'(w_op[i]);
        end
    end

    assign w_ofs = signed'(i_plane[PLANE_REG_W-1:OFS_POS]);
    assign w_sum = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2])
                 - (ACC_W'(w_ofs) <<< NRM_W);

    always_ff @(posedge i_clk) begin
        if (i_ld.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= w_prod[i];
            end
        end
        if (i_ld.sum) begin
            r_sum <= w_sum;
        end
        if (i_ld.cmp) begin
            r_pass <= ~r_sum[ACC_W-1];
        end
    end

    assign o_pass = r_pass;

endmodule

// ----- rtl/core/aabb_frustum_cull_test.sv -----
// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+-------------------------------
// box in  | input     | i_in_valid / o_in_ready    | min corner x,y,z + size x,y,z
// result  | output    | o_out_valid / i_out_ready  | o_box_visible
// config  | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index + i_cfg_data
//
// Four register stages, one box per cycle sustained while i_out_ready holds.
// Stage 1 forms 2*min and 2*min+2*size, stage 2 runs the 18 plane-axis multipliers,
// stage 3 sums them less the offset term, stage 4 keeps the sign; result = AND of six.
// Each stage has its own valid bit and loads when empty or when the one after
// it moves, so bubbles close up and a stalled result still lets new boxes in.
// Sync reset clears valid bits and planes (zero planes pass all); o_cfg_ready tied high.
module aabb_frustum_cull_test #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 11
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // box input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [COORD_BITS-1:0]          i_box_min_x,
    input  logic signed [COORD_BITS-1:0]          i_box_min_y,
    input  logic signed [COORD_BITS-1:0]          i_box_min_z,
    input  logic        [COORD_BITS-2:0]          i_box_size_x,
    input  logic        [COORD_BITS-2:0]          i_box_size_y,
    input  logic        [COORD_BITS-2:0]          i_box_size_z,
    // result
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_box_visible,
    // plane configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [afct_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [afct_pkg::PLANE_REG_W-1:0]      i_cfg_data
);
    import afct_pkg::*;

    localparam int OP_W   = COORD_BITS + 2;
    localparam int STAGES = 4;

    // plane registers
    logic [PLANE_REG_W-1:0] r_plane [PLANE_COUNT];
    logic [PLANE_REG_W-1:0] n_plane [PLANE_COUNT];

    // pipeline control: ld[k] loads stage k, ld[STAGES+1] is the sink
    logic [STAGES:1]   r_vld;
    logic [STAGES+1:1] w_ld;
    t_stage_ld         w_unit_ld;

    // stage 1 operands
    logic signed [COORD_BITS-1:0] w_min  [3];
    logic        [COORD_BITS-2:0] w_size [3];
    logic signed [OP_W-1:0]       r_op_lo [3];
    logic signed [OP_W-1:0]       r_op_hi [3];
    logic signed [OP_W-1:0]       w_two_min [3];

    logic [PLANE_COUNT-1:0] w_pass;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n_plane[p] = r_plane[p];
        end
        if (i_cfg_valid) begin
            unique case (t_plane_idx'(i_cfg_index))
                PLANE_LEFT:   n_plane[PLANE_LEFT]   = i_cfg_data;
                PLANE_RIGHT:  n_plane[PLANE_RIGHT]  = i_cfg_data;
                PLANE_TOP:    n_plane[PLANE_TOP]    = i_cfg_data;
                PLANE_BOTTOM: n_plane[PLANE_BOTTOM] = i_cfg_data;
                PLANE_NEAR:   n_plane[PLANE_NEAR]   = i_cfg_data;
                PLANE_FAR:    n_plane[PLANE_FAR]    = i_cfg_data;
                default: ;    // index past the plane list: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_plane[p] <= '0;
            end
        end else begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_plane[p] <= n_plane[p];
            end
        end
    end

    // ---------------- flow control ----------------
    // a stage may load when it is empty or its content moves on
    always_comb begin
        w_ld[STAGES+1] = i_out_ready;
        for (int k = STAGES; k >= 1; k--) begin
            w_ld[k] = ~r_vld[k] | w_ld[k+1];
        end
    end

    assign o_in_ready  = w_ld[1];
    assign o_out_valid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_unit_ld.mul = w_ld[2];
    assign w_unit_ld.sum = w_ld[3];
    assign w_unit_ld.cmp = w_ld[4];

    // ---------------- stage 1: doubled center terms ----------------
    assign w_min[0]  = i_box_min_x;
    assign w_min[1]  = i_box_min_y;
    assign w_min[2]  = i_box_min_z;
    assign w_size[0] = i_box_size_x;
    assign w_size[1] = i_box_size_y;
    assign w_size[2] = i_box_size_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_two_min[i] = OP_W'(w_min[i]) <<< 1;
        end
    end

    // lo = 2*min, hi = 2*min + 2*size; both fit in COORD_BITS+2 signed
    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_op_lo[i] <= w_two_min[i];
                r_op_hi[i] <= w_two_min[i] + (signed'(OP_W'(w_size[i])) <<< 1);
            end
        end
    end

    // ---------------- stages 2..4: one unit per plane ----------------
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        afct_plane_unit #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_plane (
            .i_clk   (i_clk),
            .i_ld    (w_unit_ld),
            .i_plane (r_plane[p]),
            .i_op_lo (r_op_lo),
            .i_op_hi (r_op_hi),
            .o_pass  (w_pass[p])
        );
    end

    // visible only when no plane rejects the box
    assign o_box_visible = &w_pass;

endmodule

// ----- rtl/core/afct_checker.sv -----
module afct_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_ready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  o_box_visible
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid & o_in_ready;

    // an empty output stage means the whole pipe can take a word
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // an accepted word reaches the output when the sink keeps taking
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("accepted word missing after four cycles");

    // a new result word rises only when the input side was ready beforehand
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_ready))
        else $error("result appeared from a stalled pipe");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_box_visible))
        else $error("stalled result word changed");

endmodule

bind aabb_frustum_cull_test afct_checker u_afct_checker (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import afct_pkg::*;

    // DUT geometry (defaults of the block)
    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 11;
    localparam int NRM_W            = NORMAL_FRAC_BITS + 1;
    localparam int OFS_POS          = 3 * NRM_W;
    localparam int OFS_W            = PLANE_REG_W - OFS_POS;

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint SIZE_MAX  = COORD_MAX;
    localparam longint NRM_MAX   = (64'sd1 <<< (NRM_W - 1)) - 1;
    localparam longint NRM_MIN   = -NRM_MAX - 1;
    localparam longint OFS_MAX   = (64'sd1 <<< (OFS_W - 1)) - 1;
    localparam longint OFS_MIN   = -OFS_MAX - 1;

    // register indexes past the plane file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(PLANE_COUNT);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

    // pipeline is four stages; the settle time adds a margin to that depth before touching planes
    localparam int PIPE_DEPTH     = 4;
    localparam int SETTLE_CYCLES  = PIPE_DEPTH + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int PLANE_SETS     = 4;
    localparam int BOXES_PER_SET  = 103;

    typedef logic [PLANE_REG_W-1:0] t_plane_word;

    // one box word; index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] corner;
        logic [2:0][COORD_BITS-2:0] extent;
    } t_box;

    logic i_clk;
    logic rst_n;

    logic                         box_valid;
    logic                         box_ready;
    logic signed [COORD_BITS-1:0] box_min_x, box_min_y, box_min_z;
    logic        [COORD_BITS-2:0] box_size_x, box_size_y, box_size_z;

    logic res_valid;
    logic res_ready = 1'b1;
    logic res_visible;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PLANE_REG_W-1:0] cfg_data;

    // predictor state: copy of the plane file as the DUT should hold it
    t_plane_word plane_shadow[PLANE_COUNT];
    // expected visibility, one bit per accepted box, oldest first
    logic visible_expected[$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int boxes_sent      = 0;
    int plane_writes    = 0;
    int results_seen    = 0;
    int boxes_visible   = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    aabb_frustum_cull_test i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (box_valid),
        .o_in_ready    (box_ready),
        .i_box_min_x   (box_min_x),
        .i_box_min_y   (box_min_y),
        .i_box_min_z   (box_min_z),
        .i_box_size_x  (box_size_x),
        .i_box_size_y  (box_size_y),
        .i_box_size_z  (box_size_z),
        .o_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .o_box_visible (res_visible),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // pack normal x,y,z (Q1.11 raw) and offset into one plane register
    function automatic t_plane_word pack_plane(longint nx, longint ny, longint nz,
                                               longint ofs);
        t_plane_word r;
        r = '0;
        r[0 +: NRM_W]         = nx[NRM_W-1:0];
        r[NRM_W +: NRM_W]     = ny[NRM_W-1:0];
        r[2 * NRM_W +: NRM_W] = nz[NRM_W-1:0];
        r[OFS_POS +: OFS_W]   = ofs[OFS_W-1:0];
        return r;
    endfunction

    function automatic t_box make_box(longint mx, longint my, longint mz,
                                      longint sx, longint sy, longint sz);
        t_box b;
        b.corner[0] = mx[COORD_BITS-1:0];
        b.corner[1] = my[COORD_BITS-1:0];
        b.corner[2] = mz[COORD_BITS-1:0];
        b.extent[0] = sx[COORD_BITS-2:0];
        b.extent[1] = sy[COORD_BITS-2:0];
        b.extent[2] = sz[COORD_BITS-2:0];
        return b;
    endfunction

    // Whole test scaled by 2*2^FRAC so it stays in integers:
    //   sum n*(2*min+size) + sum size*|n| - d*2^(FRAC+1) >= 0 for every plane
    function automatic logic predict_visible(t_box b);
        longint twice_ctr[3];
        longint span[3];
        longint acc;
        longint nrm;
        longint ofs;
        logic   vis;
        vis = 1'b1;
        for (int a = 0; a < 3; a++) begin
            span[a]      = b.extent[a];
            twice_ctr[a] = $signed(b.corner[a]);
            twice_ctr[a] = 2 * twice_ctr[a] + span[a];
        end
        for (int p = 0; p < PLANE_COUNT; p++) begin
            acc = 0;
            ofs = $signed(plane_shadow[p][OFS_POS +: OFS_W]);
            for (int a = 0; a < 3; a++) begin
                nrm = $signed(plane_shadow[p][a * NRM_W +: NRM_W]);
                acc += nrm * twice_ctr[a] + span[a] * (nrm < 0 ? -nrm : nrm);
            end
            acc -= ofs * (64'sd1 <<< (NORMAL_FRAC_BITS + 1));
            if (acc < 0) vis = 1'b0;
        end
        return vis;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // half small boxes near the origin, some full range, the rest corner values
    function automatic t_box random_box();
        t_box   b;
        int     kind;
        int     v;
        longint pick;
        kind = $urandom_range(99);
        for (int a = 0; a < 3; a++) begin
            if (kind < 50) begin
                v           = int'($urandom_range(0, 8191)) - 4096;
                b.corner[a] = v[COORD_BITS-1:0];
                b.extent[a] = (COORD_BITS - 1)'($urandom_range(0, 4096));
            end else if (kind < 80) begin
                b.corner[a] = COORD_BITS'($urandom);
                b.extent[a] = (COORD_BITS - 1)'($urandom);
            end else begin
                case ($urandom_range(4))
                    0:       pick = COORD_MIN;
                    1:       pick = COORD_MAX;
                    2:       pick = 0;
                    3:       pick = -1;
                    default: pick = $signed(COORD_BITS'($urandom));
                endcase
                b.corner[a] = pick[COORD_BITS-1:0];
                case ($urandom_range(3))
                    0:       pick = 0;
                    1:       pick = SIZE_MAX;
                    2:       pick = 1;
                    default: pick = $urandom_range(0, 32'(SIZE_MAX));
                endcase
                b.extent[a] = pick[COORD_BITS-2:0];
            end
        end
        return b;
    endfunction

    // mostly loose planes so visible boxes are common; also raw words,
    // degenerate zero normals and full-scale extremes
    function automatic t_plane_word random_plane();
        int     kind;
        longint n[3];
        longint ofs;
        kind = $urandom_range(99);
        if (kind < 60) begin
            for (int a = 0; a < 3; a++) n[a] = longint'($urandom_range(0, 4095)) - 2048;
            ofs = longint'($urandom_range(0, 24000)) - 20000;
            return pack_plane(n[0], n[1], n[2], ofs);
        end else if (kind < 75) begin
            return {$urandom, $urandom};
        end else if (kind < 85) begin
            ofs = longint'($urandom_range(0, 4)) - 2;
            return pack_plane(0, 0, 0, ofs);
        end else begin
            for (int a = 0; a < 3; a++) begin
                case ($urandom_range(2))
                    0:       n[a] = NRM_MIN;
                    1:       n[a] = NRM_MAX;
                    default: n[a] = 0;
                endcase
            end
            case ($urandom_range(3))
                0:       ofs = OFS_MIN;
                1:       ofs = OFS_MAX;
                2:       ofs = 0;
                default: ofs = -1;
            endcase
            return pack_plane(n[0], n[1], n[2], ofs);
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sender: random gap cycles, then hold the word until accepted. Valid is
    // dropped only in gap cycles, so back-to-back words see a single assignment.
    task automatic send_box(t_box b);
        while ($urandom_range(99) < sender_idle_pct) begin
            box_valid <= 1'b0;
            @(posedge i_clk);
        end
        box_valid  <= 1'b1;
        box_min_x  <= b.corner[0];
        box_min_y  <= b.corner[1];
        box_min_z  <= b.corner[2];
        box_size_x <= b.extent[0];
        box_size_y <= b.extent[1];
        box_size_z <= b.extent[2];
        @(posedge i_clk);
        while (!box_ready) @(posedge i_clk);
        // planes only change while idle, so predicting now is safe
        visible_expected.push_back(predict_visible(b));
        boxes_sent++;
    endtask

    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, t_plane_word value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx < PLANE_COUNT) plane_shadow[idx] = value;
        plane_writes++;
    endtask

    task automatic load_planes(t_plane_word planes[PLANE_COUNT]);
        for (int p = 0; p < PLANE_COUNT; p++) write_plane(t_plane_idx'(p), planes[p]);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every result come out, then let the pipe settle
    task automatic wait_idle();
        box_valid <= 1'b0;
        while (visible_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) res_ready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_result
        logic want_vis;
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            if (res_visible) boxes_visible++;
            if (visible_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %0d visible=%0b with no box pending",
                             results_seen, res_visible);
            end else begin
                want_vis = visible_expected.pop_front();
                if (res_visible !== want_vis) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result %0d visible expected %0b got %0b",
                                 results_seen, want_vis, res_visible);
                end
            end
        end
    end

    // Watchdog: too long without any handshake on any channel
    always @(posedge i_clk) begin
        if ((box_valid && box_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog, no handshake for %0d cycles", idle_cycles);
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // planes are all zero after reset: every box must pass
    task automatic test_reset_planes();
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-1, -1, -1, 1, 1, 1));
        send_box(make_box(COORD_MAX, COORD_MIN, 0, SIZE_MAX, 0, 1));
        wait_idle();
    endtask

    // indexes past the last plane: a culling word there must change nothing
    task automatic test_unused_index();
        write_plane(IDX_SPARE_LO, pack_plane(0, 0, 0, OFS_MAX));
        write_plane(IDX_SPARE_HI, pack_plane(0, 0, 0, 1));
        cfg_valid <= 1'b0;
        send_box(make_box(100, -200, 300, 5, 6, 7));
        send_box(make_box(COORD_MIN, COORD_MAX, 0, SIZE_MAX, 0, SIZE_MAX));
        wait_idle();
    endtask

    // zero normal: plane passes exactly when the offset is not positive
    task automatic test_zero_normal();
        t_plane_word planes[PLANE_COUNT];
        longint      offsets[5];
        offsets = '{1, 0, -1, OFS_MAX, OFS_MIN};
        foreach (offsets[k]) begin
            for (int p = 0; p < PLANE_COUNT; p++) planes[p] = '0;
            planes[PLANE_NEAR] = pack_plane(0, 0, 0, offsets[k]);
            load_planes(planes);
            send_box(make_box(1234, -5678, 42, 9, 10, 11));
            wait_idle();
        end
    endtask

    // odd sizes: boxes sit exactly on, or one unit short of, the boundary
    task automatic test_odd_sizes();
        t_plane_word planes[PLANE_COUNT];
        for (int p = 0; p < PLANE_COUNT; p++) planes[p] = '0;
        // nx = 2047, d = 2047: passes iff min_x + size_x >= 2048
        planes[PLANE_LEFT]  = pack_plane(NRM_MAX, 0, 0, NRM_MAX);
        // ny = -1.0, d = -100: passes iff min_y <= 100
        planes[PLANE_RIGHT] = pack_plane(0, NRM_MIN, 0, -100);
        load_planes(planes);
        send_box(make_box(1001, 100, 0, 1047, 3, 1));
        send_box(make_box(1000, 100, 0, 1047, 3, 1));
        send_box(make_box(1001, 101, 0, 1047, 3, 1));
        send_box(make_box(-7, -9, 5, 2055, 1, 3));
        wait_idle();
    endtask

    // full-scale normals and offsets on every plane
    task automatic test_extreme_planes();
        t_plane_word planes[PLANE_COUNT];
        planes[PLANE_LEFT]   = pack_plane(NRM_MIN, NRM_MIN, NRM_MIN, OFS_MIN);
        planes[PLANE_RIGHT]  = pack_plane(NRM_MAX, NRM_MAX, NRM_MAX, OFS_MAX);
        planes[PLANE_TOP]    = pack_plane(NRM_MAX, NRM_MIN, NRM_MAX, OFS_MIN);
        planes[PLANE_BOTTOM] = pack_plane(NRM_MIN, NRM_MAX, NRM_MIN, OFS_MAX);
        planes[PLANE_NEAR]   = pack_plane(NRM_MIN, NRM_MIN, NRM_MIN, OFS_MIN);
        planes[PLANE_FAR]    = pack_plane(NRM_MAX, NRM_MAX, NRM_MAX, OFS_MIN);
        load_planes(planes);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, SIZE_MAX, 0, SIZE_MAX));
        wait_idle();
        // every offset at its most negative: large margins, all should pass
        for (int p = 0; p < PLANE_COUNT; p++)
            planes[p] = pack_plane(NRM_MAX, NRM_MIN, NRM_MAX, OFS_MIN);
        load_planes(planes);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, SIZE_MAX, 0, SIZE_MAX));
        wait_idle();
    endtask

    // random planes and boxes under one idling pattern
    task automatic test_random_traffic(int idle_pct, int stall);
        t_plane_word planes[PLANE_COUNT];
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        for (int s = 0; s < PLANE_SETS; s++) begin
            for (int p = 0; p < PLANE_COUNT; p++) planes[p] = random_plane();
            load_planes(planes);
            for (int i = 0; i < BOXES_PER_SET; i++) send_box(random_box());
            wait_idle();
        end
    endtask

    initial begin
        // every DUT input known from time zero
        rst_n      = 1'b0;
        box_valid  = 1'b0;
        box_min_x  = '0;
        box_min_y  = '0;
        box_min_z  = '0;
        box_size_x = '0;
        box_size_y = '0;
        box_size_z = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        for (int p = 0; p < PLANE_COUNT; p++) plane_shadow[p] = '0;

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_planes();
        test_unused_index();
        test_zero_normal();
        test_odd_sizes();
        test_extreme_planes();
        test_random_traffic(0, 0);
        test_random_traffic(73, 0);
        test_random_traffic(0, 73);
        test_random_traffic(31, 31);
        stall_pct = 0;
        wait_idle();

        $display("summary: %0d boxes, %0d results (%0d visible, %0d culled), %0d plane writes",
                 boxes_sent, results_seen, boxes_visible, results_seen - boxes_visible,
                 plane_writes);
        $display("summary: idle/stall patterns none, sender, receiver, both; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && visible_expected.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
